/* src/fbct_pkg.sv */
package fbct_pkg;

   // Table geometry and field widths
   localparam int TABLE_DEPTH = 16;
   localparam int ADDR_BITS   = 16;
   localparam int FIELD_W     = 16;
   localparam int CMD_W       = 2;
   localparam int STAT_W      = 2;
   localparam int COUNT_W     = 5;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   // Command codes
   localparam logic [CMD_W-1:0] CMD_APPEND  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_DUMP    = 2'd2;

   // Status codes
   localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
   localparam logic [STAT_W-1:0] STAT_FULL = 2'd1;
   localparam logic [STAT_W-1:0] STAT_OVF  = 2'd2;

   typedef logic [ADDR_BITS-1:0] addr_type;
   typedef logic [IDX_W-1:0]     idx_type;
   typedef logic [CNT_W-1:0]     cnt_type;

   typedef struct packed {
      addr_type start;
      addr_type length;
   } entry_type;

   // One access slot of the segment table: one write and one read per cycle
   typedef struct packed {
      logic      wr_en;
      idx_type   wr_addr;
      entry_type wr_data;
      logic      rd_en;
      idx_type   rd_addr;
   } ram_req_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_SHIFT,
      ST_INSERT,
      ST_DUMP_RD,
      ST_DUMP_OUT,
      ST_DONE
   } state_type;

endpackage

/* src/free_block_coalescing_table_unit.sv */
// Channel   Direction  Handshake          Payload
// req_      in         req_valid/stall    req_cmd, req_seg_start, req_seg_length
// rsp_      out        rsp_valid/stall    rsp_entry_start, rsp_entry_length,
//                                         rsp_status, rsp_entry_count, rsp_last
//
// One transaction is worked at a time; table reads and writes, one of each a cycle, set the pace.
// Append and unused commands go straight to the result. Release scans from the head (up to the
// entry count), then decides, then shifts any entries that move and fills an opened slot.
// Dump reads and emits each entry in turn; an empty table gives only the status result.
// Reset empties the table at once (the count clears); table contents are not cleared.
// A stalled result holds the machine in its emit state; req_stall is high while busy.
module free_block_coalescing_table_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [fbct_pkg::CMD_W-1:0]    req_cmd,
   input  logic [fbct_pkg::FIELD_W-1:0]  req_seg_start,
   input  logic [fbct_pkg::FIELD_W-1:0]  req_seg_length,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [fbct_pkg::FIELD_W-1:0]  rsp_entry_start,
   output logic [fbct_pkg::FIELD_W-1:0]  rsp_entry_length,
   output logic [fbct_pkg::STAT_W-1:0]   rsp_status,
   output logic [fbct_pkg::COUNT_W-1:0]  rsp_entry_count,
   output logic                          rsp_last
);
   import fbct_pkg::*;

   localparam int SUM_W = ADDR_BITS + 2;

   state_type   state_ff, state_in;
   cnt_type     count_ff, count_in;
   cnt_type     ptr_ff, ptr_in;
   cnt_type     pos_ff, pos_in;
   cnt_type     left_ff, left_in;
   logic        pend_ff, pend_in;
   idx_type     pend_addr_ff, pend_addr_in;
   logic        dir_up_ff, dir_up_in;
   addr_type    s_ff, s_in;
   addr_type    l_ff, l_in;
   entry_type   prev_ff, prev_in;
   entry_type   next_ff, next_in;
   logic [STAT_W-1:0] status_ff, status_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [FIELD_W-1:0]   rsp_start_ff, rsp_start_in;
   logic [FIELD_W-1:0]   rsp_length_ff, rsp_length_in;
   logic [STAT_W-1:0]    rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0]   rsp_count_ff, rsp_count_in;
   logic                 rsp_last_ff, rsp_last_in;

   ram_req_type ram_req;
   entry_type   rd;

   logic        accept;
   logic        out_free;
   logic        full;
   logic        scan_hit;
   logic        scan_end;
   logic        dump_last;
   logic        has_prev;
   logic        has_next;
   logic        touch_prev;
   logic        touch_next;
   logic        overflow;
   logic [ADDR_BITS:0] prev_end;
   logic [ADDR_BITS:0] seg_end;
   logic [SUM_W-1:0]   merged_sum;
   addr_type    merged_len;
   addr_type    req_s;
   addr_type    req_l;

   fbct_table_ram u_table (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (rd)
   );

   // Handshake conditions
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_s     = ADDR_BITS'(req_seg_start);
   assign req_l     = ADDR_BITS'(req_seg_length);
   assign full      = (count_ff == CNT_W'(TABLE_DEPTH));

   // Scan and dump position tests
   assign scan_hit  = (rd.start > s_ff);
   assign scan_end  = ((ptr_ff + 1'b1) == count_ff);
   assign dump_last = ((ptr_ff + 1'b1) == count_ff);

   // Neighbor contact and merged length
   assign has_prev   = (pos_ff != '0);
   assign has_next   = (pos_ff < count_ff);
   assign prev_end   = {1'b0, prev_ff.start} + {1'b0, prev_ff.length};
   assign seg_end    = {1'b0, s_ff} + {1'b0, l_ff};
   assign touch_prev = has_prev && (prev_end == {1'b0, s_ff});
   assign touch_next = has_next && (seg_end == {1'b0, next_ff.start});
   assign merged_sum = (touch_prev ? SUM_W'(prev_ff.length) : '0)
                     + SUM_W'(l_ff)
                     + (touch_next ? SUM_W'(next_ff.length) : '0);
   assign overflow   = (merged_sum[SUM_W-1:ADDR_BITS] != '0);
   assign merged_len = merged_sum[ADDR_BITS-1:0];

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_cmd == CMD_RELEASE) begin
                  state_in = (count_ff == '0) ? ST_DECIDE : ST_SCAN;
               end else if (req_cmd == CMD_DUMP && count_ff != '0) begin
                  state_in = ST_DUMP_RD;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_SCAN: begin
            if (scan_hit || scan_end) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            state_in = ST_DONE;
            if (touch_prev || touch_next) begin
               if (!overflow && touch_prev && touch_next &&
                   (pos_ff + 1'b1) < count_ff) begin
                  state_in = ST_SHIFT;
               end
            end else if (!full && pos_ff != count_ff) begin
               state_in = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            if (left_ff == '0) begin
               state_in = dir_up_ff ? ST_INSERT : ST_DONE;
            end
         end
         ST_INSERT: begin
            state_in = ST_DONE;
         end
         ST_DUMP_RD: begin
            state_in = ST_DUMP_OUT;
         end
         ST_DUMP_OUT: begin
            if (out_free) begin
               state_in = dump_last ? ST_IDLE : ST_DUMP_RD;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath, table accesses and result loading
   always_comb begin
      count_in      = count_ff;
      ptr_in        = ptr_ff;
      pos_in        = pos_ff;
      left_in       = left_ff;
      pend_in       = 1'b0;
      pend_addr_in  = pend_addr_ff;
      dir_up_in     = dir_up_ff;
      s_in          = s_ff;
      l_in          = l_ff;
      prev_in       = prev_ff;
      next_in       = next_ff;
      status_in     = status_ff;
      ram_req       = '0;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_start_in  = rsp_start_ff;
      rsp_length_in = rsp_length_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_last_in   = rsp_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               s_in      = req_s;
               l_in      = req_l;
               status_in = STAT_OK;
               ptr_in    = '0;
               case (req_cmd)
                  CMD_APPEND: begin
                     // Append at the tail unless the table is full
                     if (full) begin
                        status_in = STAT_FULL;
                     end else begin
                        ram_req.wr_en   = 1'b1;
                        ram_req.wr_addr = IDX_W'(count_ff);
                        ram_req.wr_data = '{start: req_s, length: req_l};
                        count_in        = count_ff + 1'b1;
                     end
                  end
                  CMD_RELEASE: begin
                     // Start the scan at the head, or go straight to decide
                     pos_in = '0;
                     if (count_ff != '0) begin
                        ram_req.rd_en   = 1'b1;
                        ram_req.rd_addr = '0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // Stop at the first entry whose start lies above the segment
            if (scan_hit) begin
               pos_in  = ptr_ff;
               next_in = rd;
            end else if (scan_end) begin
               prev_in = rd;
               pos_in  = count_ff;
            end else begin
               prev_in         = rd;
               ptr_in          = ptr_ff + 1'b1;
               ram_req.rd_en   = 1'b1;
               ram_req.rd_addr = IDX_W'(ptr_ff + 1'b1);
            end
         end
         ST_DECIDE: begin
            if (touch_prev || touch_next) begin
               if (overflow) begin
                  status_in = STAT_OVF;
               end else if (touch_prev) begin
                  // Grow the predecessor; close the gap when the successor joins
                  ram_req.wr_en   = 1'b1;
                  ram_req.wr_addr = IDX_W'(pos_ff - 1'b1);
                  ram_req.wr_data = '{start: prev_ff.start, length: merged_len};
                  if (touch_next) begin
                     count_in  = count_ff - 1'b1;
                     ptr_in    = pos_ff + 1'b1;
                     left_in   = count_ff - pos_ff - 1'b1;
                     dir_up_in = 1'b0;
                  end
               end else begin
                  // Pull the successor's start down to the segment
                  ram_req.wr_en   = 1'b1;
                  ram_req.wr_addr = IDX_W'(pos_ff);
                  ram_req.wr_data = '{start: s_ff, length: merged_len};
               end
            end else if (full) begin
               status_in = STAT_FULL;
            end else if (pos_ff == count_ff) begin
               // Insert at the tail
               ram_req.wr_en   = 1'b1;
               ram_req.wr_addr = IDX_W'(pos_ff);
               ram_req.wr_data = '{start: s_ff, length: l_ff};
               count_in        = count_ff + 1'b1;
            end else begin
               // Open a slot: move entries up from the tail
               ptr_in    = count_ff - 1'b1;
               left_in   = count_ff - pos_ff;
               dir_up_in = 1'b1;
            end
         end
         ST_SHIFT: begin
            // Write back the entry read last cycle, one place over
            if (pend_ff) begin
               ram_req.wr_en   = 1'b1;
               ram_req.wr_addr = dir_up_ff ? (pend_addr_ff + 1'b1) : (pend_addr_ff - 1'b1);
               ram_req.wr_data = rd;
            end
            // Issue the next read while entries remain
            if (left_ff != '0) begin
               ram_req.rd_en   = 1'b1;
               ram_req.rd_addr = IDX_W'(ptr_ff);
               pend_in         = 1'b1;
               pend_addr_in    = IDX_W'(ptr_ff);
               ptr_in          = dir_up_ff ? (ptr_ff - 1'b1) : (ptr_ff + 1'b1);
               left_in         = left_ff - 1'b1;
            end
         end
         ST_INSERT: begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = IDX_W'(pos_ff);
            ram_req.wr_data = '{start: s_ff, length: l_ff};
            count_in        = count_ff + 1'b1;
         end
         ST_DUMP_RD: begin
            ram_req.rd_en   = 1'b1;
            ram_req.rd_addr = IDX_W'(ptr_ff);
         end
         ST_DUMP_OUT: begin
            // Emit one entry per transaction
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_start_in  = FIELD_W'(rd.start);
               rsp_length_in = FIELD_W'(rd.length);
               rsp_status_in = STAT_OK;
               rsp_count_in  = COUNT_W'(count_ff);
               rsp_last_in   = dump_last;
               ptr_in        = ptr_ff + 1'b1;
            end
         end
         ST_DONE: begin
            // Emit the single status transaction
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_start_in  = '0;
               rsp_length_in = '0;
               rsp_status_in = status_ff;
               rsp_count_in  = COUNT_W'(count_ff);
               rsp_last_in   = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working and result payload registers
   always_ff @(posedge clock) begin
      ptr_ff        <= ptr_in;
      pos_ff        <= pos_in;
      left_ff       <= left_in;
      pend_addr_ff  <= pend_addr_in;
      dir_up_ff     <= dir_up_in;
      s_ff          <= s_in;
      l_ff          <= l_in;
      prev_ff       <= prev_in;
      next_ff       <= next_in;
      status_ff     <= status_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_length_ff <= rsp_length_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_entry_start  = rsp_start_ff;
   assign rsp_entry_length = rsp_length_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_entry_count  = rsp_count_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

/* src/fbct_table_ram.sv */
module fbct_table_ram (
   input  logic                  clock,
   input  fbct_pkg::ram_req_type ram_req,
   output fbct_pkg::entry_type   rd_data
);
   import fbct_pkg::*;

   entry_type table_mem [TABLE_DEPTH];
   entry_type rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         table_mem[ram_req.wr_addr] <= ram_req.wr_data;
      end
   end

   // Registered read port; hold data while no read is issued
   always_ff @(posedge clock) begin
      if (ram_req.rd_en) begin
         rd_data_ff <= table_mem[ram_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
